// ----- rtl/core/rwti_pkg.sv -----
// Shared types, constants and helpers for the room wall thermal integrator.
package rwti_pkg;

  localparam int MUL_WA = 40;
  localparam int MUL_WB = 32;
  localparam int MUL_WP = MUL_WA + MUL_WB;
  localparam int MUL_CW = $clog2(MUL_WB);
  localparam int DIV_W  = 32;
  localparam int DIV_CW = $clog2(DIV_W);

  localparam logic signed [15:0] TEMP_MIN = -16'sd10240;
  localparam logic signed [15:0] TEMP_MAX = 16'sd30720;

  localparam logic [2:0] REG_STEP     = 3'd0;
  localparam logic [2:0] REG_AIR_INV  = 3'd1;
  localparam logic [2:0] REG_WALL_INV = 3'd2;
  localparam logic [2:0] REG_CONV_G   = 3'd3;
  localparam logic [2:0] REG_LEAK_G   = 3'd4;
  localparam logic [2:0] REG_LEAK_B   = 3'd5;
  localparam logic [2:0] REG_WALL_IN  = 3'd6;
  localparam logic [2:0] REG_WALL_OUT = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_DIV, ST_LEAK, ST_DISP, ST_WIN, ST_WOUT,
    ST_CG, ST_CONV, ST_PA, ST_SA, ST_PW, ST_SW, ST_DONE
  } state_t;

  typedef struct packed {
    logic                     start;
    logic signed [MUL_WA-1:0] a;
    logic [MUL_WB-1:0]        b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [MUL_WP-1:0] p;
  } mul_rsp_t;

  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    logic [31:0] r;
    if (v > 40'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -40'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_temp(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v < 48'(TEMP_MIN)) r = TEMP_MIN;
    else if (v > 48'(TEMP_MAX)) r = TEMP_MAX;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/rwti_smul.sv -----
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier.
module rwti_smul import rwti_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [MUL_CW-1:0]        cnt_r, cnt_nxt;
  logic signed [MUL_WA:0]   hi_r, hi_nxt;
  logic [MUL_WB-1:0]        lo_r, lo_nxt;
  logic signed [MUL_WA-1:0] a_r, a_nxt;
  logic signed [MUL_WA:0]   sum;

  // one multiplier bit per cycle, partial product shifts right
  always_comb begin
    sum      = hi_r + (lo_r[0] ? {a_r[MUL_WA-1], a_r} : '0);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    a_nxt    = a_r;
    if (req.start) begin
      a_nxt    = req.a;
      hi_nxt   = '0;
      lo_nxt   = req.b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = sum >>> 1;
      lo_nxt  = {sum[0], lo_r[MUL_WB-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MUL_CW'(MUL_WB - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    a_r  <= a_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.p    = {hi_r[MUL_WA-1:0], lo_r};

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("multiplier restarted while busy");

endmodule

// ----- rtl/core/rwti_sdiv.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module rwti_sdiv import rwti_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [15:0]      divisor,
  output logic             done,
  output logic [DIV_W-1:0] quo
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [DIV_W-1:0]  n_r, n_nxt;
  logic [16:0]       r2;
  logic              ge;

  always_comb begin
    r2       = {rem_r, n_r[DIV_W-1]};
    ge       = (r2 >= {1'b0, divisor});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    n_nxt    = n_r;
    if (start) begin
      rem_nxt  = '0;
      n_nxt    = num;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? 16'(r2 - {1'b0, divisor}) : r2[15:0];
      n_nxt   = {n_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    n_r   <= n_nxt;
  end

  assign done = done_r;
  assign quo  = n_r;

endmodule

// ----- rtl/core/room_wall_thermal_integrator.sv -----
// Room wall thermal integrator: one Euler step of a two-node air/wall model per item.
// The item is loaded on acceptance, and the INIT state then applies a restart.
// Then comes one pass through the bit-serial divider for the convection fade,
// which yields 32 quotient bits. Then come ten passes through one shared
// bit-serial multiplier: leak, displaced air, the two wall heats, convection in
// two steps, and the step-time product plus integration for each node. The DONE
// state then posts the result. One item is in work at a time. The finished
// result sits in an output register, so the next item is taken while it waits.
// Configuration is to be written by the user only while idle; the block itself
// does not enforce this.
module room_wall_thermal_integrator import rwti_pkg::*; #(
  parameter int AIR_SPECIFIC_HEAT_Q = 61,
  parameter int CONV_FADE_LOW       = 0,
  parameter int CONV_FADE_HIGH      = 4096,
  parameter int WALL_START_RATIO_Q  = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // duct_heat, flow_now, flow_lagged, heater_temp, outdoor_temp, extra_heat,
  // setpoint_temp
  input  logic [143:0] in_tdata,
  // restart
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // air_temp_out, wall_temp_out, conv_heat, net_air_heat, leak_heat
  output logic [127:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_idx,
  input  logic [31:0]  cfg_wdata
);

  localparam logic [7:0]  CP        = 8'(AIR_SPECIFIC_HEAT_Q);
  localparam logic [8:0]  RATIO     = 9'(WALL_START_RATIO_Q);
  localparam logic [15:0] FADE_LOW  = 16'(CONV_FADE_LOW);
  localparam logic [15:0] FADE_HIGH = 16'(CONV_FADE_HIGH);
  localparam logic [15:0] FADE_SPAN = 16'(CONV_FADE_HIGH - CONV_FADE_LOW);

  // configuration
  logic [15:0]        step_r, ainv_r, winv_r, cgain_r, lgain_r, gin_r, gout_r;
  logic signed [31:0] lbias_r;

  // latched item
  logic               restart_i;
  logic signed [31:0] duct_i, extra_i;
  logic [15:0]        flow_i, flowl_i;
  logic signed [15:0] heat_i, oat_i, setp_i;

  // state and intermediates
  state_t             state_r, state_nxt;
  logic               go_r;
  logic signed [15:0] air_r, wall_r;
  logic signed [33:0] leak_r, cg_r;
  logic signed [24:0] disp_r;
  logic signed [22:0] win_r, wout_r, conv_r;
  logic [31:0]        pr_r;
  logic [16:0]        fade_r;
  logic               out_valid_r;
  logic [127:0]       out_data_r;

  mul_req_t           mreq;
  mul_rsp_t           mrsp;
  logic               div_start, div_done;
  logic [31:0]        div_quo;

  logic signed [16:0] d_ha, d_aw, d_wo, rs_diff;
  logic signed [24:0] ta_cp;
  logic signed [26:0] rs_mul, rs_w;
  logic signed [15:0] rs_wall;
  logic signed [36:0] air_sum;
  logic signed [23:0] wall_sum;
  logic signed [MUL_WP-1:0] prod;
  logic               is_mul, out_free;

  rwti_smul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  rwti_sdiv u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num({16'(flow_i - FADE_LOW), 16'h0000}), .divisor(FADE_SPAN),
    .done(div_done), .quo(div_quo)
  );

  assign prod     = mrsp.p;
  assign d_ha     = 17'(heat_i) - 17'(air_r);
  assign d_aw     = 17'(air_r) - 17'(wall_r);
  assign d_wo     = 17'(wall_r) - 17'(oat_i);
  assign ta_cp    = air_r * $signed({1'b0, CP});
  assign rs_diff  = 17'(setp_i) - 17'(oat_i);
  assign rs_mul   = rs_diff * $signed({1'b0, RATIO});
  assign rs_w     = 27'(oat_i) + (rs_mul >>> 8);
  assign rs_wall  = (rs_w < 27'(setp_i)) ? rs_w[15:0] : setp_i;
  assign air_sum  = 37'(duct_i) + 37'(leak_r) - 37'(disp_r) - 37'(win_r)
                  + 37'(conv_r) + 37'(extra_i);
  assign wall_sum = 24'(win_r) - 24'(wout_r);
  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_INIT;
      ST_INIT: state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_LEAK;
      ST_LEAK: if (mrsp.done) state_nxt = ST_DISP;
      ST_DISP: if (mrsp.done) state_nxt = ST_WIN;
      ST_WIN:  if (mrsp.done) state_nxt = ST_WOUT;
      ST_WOUT: if (mrsp.done) state_nxt = ST_CG;
      ST_CG:   if (mrsp.done) state_nxt = ST_CONV;
      ST_CONV: if (mrsp.done) state_nxt = ST_PA;
      ST_PA:   if (mrsp.done) state_nxt = ST_SA;
      ST_SA:   if (mrsp.done) state_nxt = ST_PW;
      ST_PW:   if (mrsp.done) state_nxt = ST_SW;
      ST_SW:   if (mrsp.done) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs: unit starts and multiplier operands
  always_comb begin
    is_mul    = state_r inside {ST_LEAK, ST_DISP, ST_WIN, ST_WOUT, ST_CG, ST_CONV,
                                ST_PA, ST_SA, ST_PW, ST_SW};
    in_tready = (state_r == ST_IDLE);
    div_start = (state_r == ST_DIV) && !go_r;
    mreq.start = is_mul && !go_r;
    mreq.a     = '0;
    mreq.b     = '0;
    unique case (state_r)
      ST_LEAK: begin mreq.a = 40'(d_ha);    mreq.b = 32'(lgain_r); end
      ST_DISP: begin mreq.a = 40'(ta_cp);   mreq.b = 32'(flowl_i); end
      ST_WIN:  begin mreq.a = 40'(d_aw);    mreq.b = 32'(gin_r);   end
      ST_WOUT: begin mreq.a = 40'(d_wo);    mreq.b = 32'(gout_r);  end
      ST_CG:   begin mreq.a = 40'(d_ha);    mreq.b = 32'(cgain_r); end
      ST_CONV: begin mreq.a = 40'(cg_r);    mreq.b = 32'(fade_r);  end
      ST_PA:   begin mreq.a = 40'({1'b0, step_r}); mreq.b = 32'(ainv_r); end
      ST_SA:   begin mreq.a = 40'(air_sum); mreq.b = pr_r;         end
      ST_PW:   begin mreq.a = 40'({1'b0, step_r}); mreq.b = 32'(winv_r); end
      ST_SW:   begin mreq.a = 40'(wall_sum); mreq.b = pr_r;        end
      default: begin mreq.a = '0;           mreq.b = '0;           end
    endcase
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      air_r       <= '0;
      wall_r      <= '0;
      step_r      <= '0;
      ainv_r      <= '0;
      winv_r      <= '0;
      cgain_r     <= '0;
      lgain_r     <= '0;
      lbias_r     <= '0;
      gin_r       <= '0;
      gout_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (mreq.start || div_start) go_r <= 1'b1;
      else if (mrsp.done || div_done) go_r <= 1'b0;
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (state_r == ST_INIT && restart_i) begin
        air_r  <= setp_i;
        wall_r <= rs_wall;
      end
      if (mrsp.done && state_r == ST_SA)
        air_r <= clamp_temp(48'(air_r) + 48'(prod >>> 28));
      if (mrsp.done && state_r == ST_SW)
        wall_r <= clamp_temp(48'(wall_r) + 48'(prod >>> 28));
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_STEP:     step_r  <= cfg_wdata[15:0];
          REG_AIR_INV:  ainv_r  <= cfg_wdata[15:0];
          REG_WALL_INV: winv_r  <= cfg_wdata[15:0];
          REG_CONV_G:   cgain_r <= cfg_wdata[15:0];
          REG_LEAK_G:   lgain_r <= cfg_wdata[15:0];
          REG_LEAK_B:   lbias_r <= cfg_wdata;
          REG_WALL_IN:  gin_r   <= cfg_wdata[15:0];
          REG_WALL_OUT: gout_r  <= cfg_wdata[15:0];
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      restart_i <= in_tuser[0];
      duct_i    <= in_tdata[31:0];
      flow_i    <= in_tdata[47:32];
      flowl_i   <= in_tdata[63:48];
      heat_i    <= in_tdata[79:64];
      oat_i     <= in_tdata[95:80];
      extra_i   <= in_tdata[127:96];
      setp_i    <= in_tdata[143:128];
    end
    if (div_done) begin
      if (flow_i <= FADE_LOW) fade_r <= 17'h10000;
      else if (flow_i >= FADE_HIGH) fade_r <= '0;
      else fade_r <= 17'h10000 - {1'b0, div_quo[15:0]};
    end
    if (mrsp.done) begin
      case (state_r)
        ST_LEAK: leak_r <= 34'(prod >>> 12) + 34'(lbias_r);
        ST_DISP: disp_r <= 25'(prod >>> 16);
        ST_WIN:  win_r  <= 23'(prod >>> 12);
        ST_WOUT: wout_r <= 23'(prod >>> 12);
        ST_CG:   cg_r   <= 34'(prod);
        ST_CONV: conv_r <= 23'(prod >>> 28);
        ST_PA:   pr_r   <= prod[31:0];
        ST_PW:   pr_r   <= prod[31:0];
        default: ;
      endcase
    end
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= {sat32(40'(leak_r)),
                     sat32(40'(duct_i) - 40'(disp_r)),
                     sat32(40'(conv_r)),
                     wall_r, air_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_accept_init: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_INIT))
    else $error("accepted item did not start a step");

  a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> go_r) else $error("multiplier result without a request");

  a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_tready) |=> (state_r == ST_DONE))
    else $error("result dropped while output full");

endmodule
